@@ rtl/core/spq_pkg.sv @@
// Shared types, constants and codes for the sorted insertion priority queue unit.
package spq_pkg;

   localparam int NUM_QUEUES  = 5;
   localparam int QUEUE_DEPTH = 128;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int RANK_W      = $clog2(QUEUE_DEPTH);
   localparam int RANK_IN_W   = 7;
   localparam int CMP_W       = (CNT_W > RANK_IN_W) ? CNT_W : RANK_IN_W;
   localparam int QSEL_CMP_W  = 5;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_NOT_POS    = 2'd1;
   localparam logic [1:0] STAT_FULL       = 2'd2;
   localparam logic [1:0] STAT_RANK_EMPTY = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         queue_sel;
      logic signed [23:0] bid_value;
      logic [15:0]        bidder_id;
      logic [15:0]        owner_id;
      logic [6:0]         rank;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               entry_valid;
      logic signed [23:0] entry_value;
      logic [15:0]        entry_bidder;
      logic [15:0]        entry_owner;
      logic [7:0]         queue_count;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] value;
      logic [15:0]        bidder;
      logic [15:0]        owner;
   } entry_type;

   typedef struct packed {
      logic                 insert_en;
      logic                 clear_en;
      entry_type            new_entry;
      logic [RANK_IN_W-1:0] rank;
   } qcmd_type;

   typedef struct packed {
      entry_type        top;
      entry_type        ins_top;
      entry_type        rd_entry;
      logic             rank_hit;
      logic             full;
      logic [CNT_W-1:0] count;
   } qstat_type;

endpackage

@@ rtl/core/spq_cell.sv @@
// One storage cell of a queue: holds an entry and shifts or takes a new one on insert.
module spq_cell (
   input  logic               clock,
   input  logic               insert_en,
   input  logic               valid,
   input  spq_pkg::entry_type new_entry,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_greater,
   output logic               greater,
   output spq_pkg::entry_type entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   assign greater = !valid || (new_entry.value > entry_ff.value);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (insert_en && greater) begin
         entry_in = left_greater ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/core/spq_queue.sv @@
// One sorted queue: a row of cells, its entry count and the rank read selection.
module spq_queue (
   input  logic               clock,
   input  logic               reset,
   input  spq_pkg::qcmd_type  cmd,
   output spq_pkg::qstat_type stat
);

   logic [spq_pkg::CNT_W-1:0] count_ff;
   logic [spq_pkg::CNT_W-1:0] count_in;
   spq_pkg::entry_type        cells [spq_pkg::QUEUE_DEPTH];
   logic                      greater [spq_pkg::QUEUE_DEPTH];
   logic [spq_pkg::CMP_W-1:0] rank_wide;
   logic [spq_pkg::RANK_W-1:0] rank_idx;

   for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock        (clock),
            .insert_en    (cmd.insert_en),
            .valid        (count_ff > spq_pkg::CNT_W'(i)),
            .new_entry    (cmd.new_entry),
            .left_entry   (cmd.new_entry),
            .left_greater (1'b0),
            .greater      (greater[i]),
            .entry        (cells[i])
         );
      end else begin : g_body
         spq_cell u_cell (
            .clock        (clock),
            .insert_en    (cmd.insert_en),
            .valid        (count_ff > spq_pkg::CNT_W'(i)),
            .new_entry    (cmd.new_entry),
            .left_entry   (cells[i-1]),
            .left_greater (greater[i-1]),
            .greater      (greater[i]),
            .entry        (cells[i])
         );
      end
   end

   assign rank_wide = spq_pkg::CMP_W'(cmd.rank);
   assign rank_idx  = rank_wide[spq_pkg::RANK_W-1:0];

   always_comb begin
      stat.top      = cells[0];
      stat.ins_top  = greater[0] ? cmd.new_entry : cells[0];
      stat.rd_entry = cells[rank_idx];
      stat.rank_hit = rank_wide < spq_pkg::CMP_W'(count_ff);
      stat.full     = count_ff >= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH);
      stat.count    = count_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_en) begin
         count_in = '0;
      end else if (cmd.insert_en) begin
         count_in = count_ff + spq_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/sorted_insert_priority_queue_unit.sv @@
// Top level of the sorted insertion priority queue unit: request control and result register.
//
// The block keeps a bank of independent queues, each sorted by descending bid value.
// Requests arrive on the req_ channel as one transaction per item (insert, clear or
// read at rank; spare kind reads top entry) and each yields exactly one rsp_ transaction.
// A transaction is taken at a rising edge where valid is high and stall is low.
// Every queue is a row of cells; an insert moves all smaller entries one cell back
// and drops the new entry into place in the same cycle, so inserts, clears and
// reads all take the same time.
// The request register holds an accepted request while the block is in the execute
// state; the cell rows update and the result register loads as it leaves that state.
// No new request is taken until then, as req_stall stays high in the execute state.
// A new request is taken while a finished result still waits on a stalled rsp_
// channel; that next request then holds in the execute cycle until the result
// register frees up, and req_stall stays high meanwhile.
// Reset empties every queue by clearing the entry counts; no sweep of the cells
// is needed and the block accepts requests in the first cycle after reset.
module sorted_insert_priority_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;
   spq_pkg::req_type   req_ff;
   spq_pkg::req_type   req_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spq_pkg::rsp_type   rsp_data_ff;
   spq_pkg::rsp_type   rsp_data_in;

   logic               exec_fire;
   logic               qok;
   logic               do_insert;
   logic               do_clear;
   logic [1:0]         ins_status;
   spq_pkg::entry_type new_entry;
   spq_pkg::qcmd_type  qcmd [spq_pkg::NUM_QUEUES];
   spq_pkg::qstat_type qstat [spq_pkg::NUM_QUEUES];
   logic               qhit [spq_pkg::NUM_QUEUES];
   spq_pkg::qstat_type sel;

   assign req_stall = (state_ff != spq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign exec_fire = (state_ff == spq_pkg::ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign qok = spq_pkg::QSEL_CMP_W'(req_ff.queue_sel) < spq_pkg::QSEL_CMP_W'(spq_pkg::NUM_QUEUES);

   always_comb begin
      new_entry.value  = req_ff.bid_value;
      new_entry.bidder = req_ff.bidder_id;
      new_entry.owner  = req_ff.owner_id;
   end

   always_comb begin
      sel = '0;
      for (int q = 0; q < spq_pkg::NUM_QUEUES; q++) begin
         if (qhit[q]) begin
            sel = qstat[q];
         end
      end
   end

   always_comb begin
      if (req_ff.bid_value <= 24'sd0) begin
         ins_status = spq_pkg::STAT_NOT_POS;
      end else if (!qok || sel.full) begin
         ins_status = spq_pkg::STAT_FULL;
      end else begin
         ins_status = spq_pkg::STAT_OK;
      end
   end

   assign do_insert = exec_fire && (req_ff.kind == spq_pkg::KIND_INSERT)
                      && (ins_status == spq_pkg::STAT_OK);
   assign do_clear  = exec_fire && (req_ff.kind == spq_pkg::KIND_CLEAR);

   for (genvar q = 0; q < spq_pkg::NUM_QUEUES; q++) begin : g_queue
      assign qhit[q] = qok && (spq_pkg::QSEL_CMP_W'(req_ff.queue_sel)
                               == spq_pkg::QSEL_CMP_W'(q));

      always_comb begin
         qcmd[q].insert_en = do_insert && qhit[q];
         qcmd[q].clear_en  = do_clear && qhit[q];
         qcmd[q].new_entry = new_entry;
         qcmd[q].rank      = req_ff.rank;
      end

      spq_queue u_queue (
         .clock (clock),
         .reset (reset),
         .cmd   (qcmd[q]),
         .stat  (qstat[q])
      );
   end

   always_comb begin
      rsp_data_in             = '0;
      rsp_data_in.status      = spq_pkg::STAT_OK;
      rsp_data_in.queue_count = 8'(sel.count);
      case (req_ff.kind)
         spq_pkg::KIND_INSERT: begin
            rsp_data_in.status = ins_status;
            if (ins_status == spq_pkg::STAT_OK) begin
               rsp_data_in.entry_valid  = 1'b1;
               rsp_data_in.entry_value  = sel.ins_top.value;
               rsp_data_in.entry_bidder = sel.ins_top.bidder;
               rsp_data_in.entry_owner  = sel.ins_top.owner;
               rsp_data_in.queue_count  = 8'(sel.count + spq_pkg::CNT_W'(1));
            end else if (sel.count != '0) begin
               rsp_data_in.entry_valid  = 1'b1;
               rsp_data_in.entry_value  = sel.top.value;
               rsp_data_in.entry_bidder = sel.top.bidder;
               rsp_data_in.entry_owner  = sel.top.owner;
            end
         end
         spq_pkg::KIND_CLEAR: begin
            rsp_data_in.queue_count = '0;
         end
         spq_pkg::KIND_READ: begin
            if (sel.rank_hit) begin
               rsp_data_in.entry_valid  = 1'b1;
               rsp_data_in.entry_value  = sel.rd_entry.value;
               rsp_data_in.entry_bidder = sel.rd_entry.bidder;
               rsp_data_in.entry_owner  = sel.rd_entry.owner;
            end else begin
               rsp_data_in.status = spq_pkg::STAT_RANK_EMPTY;
            end
         end
         default: begin
            if (sel.count != '0) begin
               rsp_data_in.entry_valid  = 1'b1;
               rsp_data_in.entry_value  = sel.top.value;
               rsp_data_in.entry_bidder = sel.top.bidder;
               rsp_data_in.entry_owner  = sel.top.owner;
            end
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            if (exec_fire) begin
               rsp_valid_in = 1'b1;
               state_in     = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ bench/tb_top.sv @@
// Testbench for the sorted insertion priority queue unit with a self-checking bid book.
module tb_top;

   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_SHOWN = 10;

   class bid_book;
      spq_pkg::entry_type slots[spq_pkg::NUM_QUEUES][spq_pkg::QUEUE_DEPTH];
      int unsigned        fill[spq_pkg::NUM_QUEUES];
      spq_pkg::rsp_type   awaited[$];
      int unsigned        failures;

      function new();
         foreach (fill[i]) fill[i] = 0;
         failures = 0;
      endfunction

      function int unsigned count_of(int q);
         return (q < spq_pkg::NUM_QUEUES) ? fill[q] : 0;
      endfunction

      function spq_pkg::rsp_type with_entry(spq_pkg::rsp_type res, spq_pkg::entry_type e);
         res.entry_valid  = 1'b1;
         res.entry_value  = e.value;
         res.entry_bidder = e.bidder;
         res.entry_owner  = e.owner;
         return res;
      endfunction

      function string describe(spq_pkg::rsp_type r);
         return $sformatf("status=%0d valid=%0d value=%0d bidder=%h owner=%h count=%0d",
                          r.status, r.entry_valid, r.entry_value, r.entry_bidder,
                          r.entry_owner, r.queue_count);
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= MAX_SHOWN) $display("%s", msg);
      endfunction

      function void note_request(spq_pkg::req_type r);
         spq_pkg::rsp_type res;
         int               q;
         int               pos;
         int unsigned      cnt;
         bit               qok;
         q   = int'(r.queue_sel);
         qok = q < spq_pkg::NUM_QUEUES;
         cnt = count_of(q);
         res = '0;
         case (r.kind)
            spq_pkg::KIND_INSERT: begin
               res.status = spq_pkg::STAT_OK;
               if (r.bid_value <= 0) begin
                  res.status = spq_pkg::STAT_NOT_POS;
               end else if (!qok || cnt >= spq_pkg::QUEUE_DEPTH) begin
                  res.status = spq_pkg::STAT_FULL;
               end else begin
                  pos = int'(cnt);
                  while (pos > 0 && r.bid_value > slots[q][pos-1].value) begin
                     slots[q][pos] = slots[q][pos-1];
                     pos--;
                  end
                  slots[q][pos] = '{r.bid_value, r.bidder_id, r.owner_id};
                  cnt++;
                  fill[q] = cnt;
               end
               if (cnt > 0) res = with_entry(res, slots[q][0]);
               res.queue_count = cnt[7:0];
            end
            spq_pkg::KIND_CLEAR: begin
               if (qok) fill[q] = 0;
               res.status = spq_pkg::STAT_OK;
            end
            spq_pkg::KIND_READ: begin
               if (r.rank < cnt) begin
                  res.status = spq_pkg::STAT_OK;
                  res = with_entry(res, slots[q][r.rank]);
               end else begin
                  res.status = spq_pkg::STAT_RANK_EMPTY;
               end
               res.queue_count = cnt[7:0];
            end
            default: begin
               res.status = spq_pkg::STAT_OK;
               if (cnt > 0) res = with_entry(res, slots[q][0]);
               res.queue_count = cnt[7:0];
            end
         endcase
         awaited.push_back(res);
      endfunction

      function void check_result(spq_pkg::rsp_type got);
         spq_pkg::rsp_type exp;
         bit               bad;
         if (awaited.size() == 0) begin
            flag({"unexpected result: ", describe(got)});
            return;
         end
         exp = awaited.pop_front();
         bad = 1'b0;
         if (got.status !== exp.status) bad = 1'b1;
         if (got.entry_valid !== exp.entry_valid) bad = 1'b1;
         if (got.entry_value !== exp.entry_value) bad = 1'b1;
         if (got.entry_bidder !== exp.entry_bidder) bad = 1'b1;
         if (got.entry_owner !== exp.entry_owner) bad = 1'b1;
         if (got.queue_count !== exp.queue_count) bad = 1'b1;
         if (bad) flag({"mismatch: expected ", describe(exp), " got ", describe(got)});
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   spq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   spq_pkg::rsp_type rsp_data;
   logic             hold_rsp = 1'b0;

   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bid_book book = new();
   event    hold_go;

   sorted_insert_priority_queue_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99, 0) < recv_idle_pct);
   end

   initial begin : hold_ctl
      int n;
      forever begin
         @(hold_go);
         @(posedge clock);
         hold_rsp <= 1'b1;
         for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         hold_rsp <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.note_request(req_data);
         if (rsp_valid && !rsp_stall) book.check_result(rsp_data);
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic spq_pkg::req_type make_req(logic [1:0] kind, int q, int value,
                                                 int bidder, int owner, int rank);
      spq_pkg::req_type r;
      r.kind      = kind;
      r.queue_sel = q[2:0];
      r.bid_value = value[23:0];
      r.bidder_id = bidder[15:0];
      r.owner_id  = owner[15:0];
      r.rank      = rank[6:0];
      return r;
   endfunction

   function automatic spq_pkg::req_type random_item();
      spq_pkg::req_type r;
      int               pick;
      int               neg;
      int unsigned      depth;
      r = '0;
      pick = $urandom_range(99, 0);
      if (pick < 55) r.kind = spq_pkg::KIND_INSERT;
      else if (pick < 87) r.kind = spq_pkg::KIND_READ;
      else if (pick < 91) r.kind = spq_pkg::KIND_CLEAR;
      else if (pick < 95) r.kind = KIND_SPARE;
      else r.kind = spq_pkg::KIND_INSERT;
      if ($urandom_range(99, 0) < 90) begin
         r.queue_sel = 3'($urandom_range(spq_pkg::NUM_QUEUES - 1, 0));
      end else begin
         r.queue_sel = 3'($urandom_range(7, spq_pkg::NUM_QUEUES));
      end
      pick = $urandom_range(99, 0);
      if (pick < 30) begin
         r.bid_value = 24'($urandom_range(12, 1));
      end else if (pick < 70) begin
         r.bid_value = 24'($urandom_range(8388607, 1));
      end else if (pick < 85) begin
         r.bid_value = 24'($urandom());
      end else begin
         neg = $urandom_range(3, 0);
         r.bid_value = 24'(-neg);
      end
      r.bidder_id = 16'($urandom());
      r.owner_id  = 16'($urandom());
      depth = book.count_of(int'(r.queue_sel));
      if (depth > 127) depth = 127;
      if ($urandom_range(99, 0) < 60) r.rank = 7'($urandom_range(depth, 0));
      else r.rank = 7'($urandom_range(127, 0));
      return r;
   endfunction

   task automatic send_item(input spq_pkg::req_type r);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(input int n);
      repeat (n) send_item(random_item());
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 58;
      send_item(make_req(spq_pkg::KIND_INSERT, 0, 100, 'h0001, 'hFFFF, 0));
      send_item(make_req(spq_pkg::KIND_INSERT, 0, 100, 'h0002, 'h0000, 'h7F));
      send_item(make_req(spq_pkg::KIND_INSERT, 0, 8388607, 'hFFFF, 'h0000, 0));
      send_item(make_req(spq_pkg::KIND_INSERT, 0, 1, 'h5555, 'hAAAA, 0));
      send_item(make_req(spq_pkg::KIND_INSERT, 0, 0, 'h1234, 'h4321, 0));
      send_item(make_req(spq_pkg::KIND_INSERT, 0, -8388608, 'hFFFF, 'hFFFF, 'h7F));
      send_item(make_req(spq_pkg::KIND_INSERT, 0, -1, 'hAAAA, 'h5555, 0));
      for (i = 0; i <= 4; i++) send_item(make_req(spq_pkg::KIND_READ, 0, 0, 0, 0, i));
      send_item(make_req(spq_pkg::KIND_READ, 0, 0, 0, 0, 127));
      send_item(make_req(KIND_SPARE, 0, 5, 0, 0, 0));
      send_item(make_req(spq_pkg::KIND_INSERT, 5, 50, 'h00FF, 'hFF00, 0));
      send_item(make_req(spq_pkg::KIND_CLEAR, 6, 0, 0, 0, 0));
      send_item(make_req(spq_pkg::KIND_READ, 7, 0, 0, 0, 0));
      send_item(make_req(KIND_SPARE, 7, 9, 0, 0, 0));
      send_item(make_req(spq_pkg::KIND_CLEAR, 0, 0, 0, 0, 0));
      send_item(make_req(spq_pkg::KIND_READ, 0, 0, 0, 0, 0));
      send_item(make_req(KIND_SPARE, 0, 0, 0, 0, 0));
      send_item(make_req(spq_pkg::KIND_INSERT, 4, 7, 'hBEEF, 'hCAFE, 0));
      send_item(make_req(spq_pkg::KIND_READ, 4, 0, 0, 0, 0));

      send_random(280);

      send_idle_pct = 0;
      -> hold_go;
      send_item(make_req(spq_pkg::KIND_CLEAR, 2, 0, 0, 0, 0));
      for (i = 0; i < spq_pkg::QUEUE_DEPTH + 3; i++) begin
         if ($urandom_range(1, 0) == 0) begin
            send_item(make_req(spq_pkg::KIND_INSERT, 2, $urandom_range(40, 1), $urandom(),
                               $urandom(), 0));
         end else begin
            send_item(make_req(spq_pkg::KIND_INSERT, 2, $urandom_range(8388607, 1),
                               $urandom(), $urandom(), 0));
         end
      end
      send_item(make_req(spq_pkg::KIND_READ, 2, 0, 0, 0, 127));
      send_item(make_req(spq_pkg::KIND_READ, 2, 0, 0, 0, 0));
      send_item(make_req(KIND_SPARE, 2, 0, 0, 0, 0));
      drain_results();

      send_idle_pct = 58;
      recv_idle_pct = 29;
      send_random(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(200);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.failures == 0 && book.awaited.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
